// File: hdl/sise_pkg.sv
// Shared types and codes for the sorted interval set engine.
package sise_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 1;

  typedef logic [TIME_W-1:0] stamp_t;

  typedef struct packed {
    stamp_t start;
    stamp_t stop;
    logic   kill;
  } entry_t;

  // Request operations.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // Result outcomes.
  localparam logic [1:0] OUT_DONE    = 2'd0;
  localparam logic [1:0] OUT_IGNORED = 2'd1;
  localparam logic [1:0] OUT_FULL    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'd1;

  // Cell operations.
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_EVAL = 2'd1;
  localparam logic [1:0] CELL_MARK = 2'd2;
  localparam logic [1:0] CELL_MOVE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       valid;
    logic       take_new;
    logic       shift_up;
    logic       shift_dn;
    logic       merge;
  } cell_ctl_t;

  // List operations.
  localparam logic [2:0] LIST_HOLD    = 3'd0;
  localparam logic [2:0] LIST_EVAL    = 3'd1;
  localparam logic [2:0] LIST_APPLY   = 3'd2;
  localparam logic [2:0] LIST_MARK    = 3'd3;
  localparam logic [2:0] LIST_SQUEEZE = 3'd4;
  localparam logic [2:0] LIST_FLUSH   = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       sel;
  } list_cmd_t;

  typedef struct packed {
    logic merged;
    logic full;
    logic any_kill;
  } list_stat_t;

endpackage

// File: hdl/sise_cell.sv
// One interval entry with its compare, truncate and shift logic.
module sise_cell import sise_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  stamp_t    s,
  input  stamp_t    e,
  input  entry_t    prev,
  input  entry_t    nxt,
  output entry_t    cur,
  output logic      ge,
  output logic      le
);

  stamp_t new_start;
  stamp_t new_stop;
  logic   overlap;

  always_comb begin
    new_start = (cur.start > s) ? e : cur.start;
    new_stop  = (cur.stop < e) ? s : cur.stop;
    overlap   = ctl.valid && !(cur.stop < s || cur.start > e);
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_EVAL: begin
        ge <= (cur.stop >= s);
        le <= (cur.start <= e);
      end
      CELL_MARK: begin
        if (overlap) begin
          cur.start <= new_start;
          cur.stop  <= new_stop;
          cur.kill  <= (new_start >= new_stop);
        end else begin
          cur.kill <= 1'b0;
        end
      end
      CELL_MOVE: begin
        if (ctl.take_new) begin
          cur.start <= s;
          cur.stop  <= e;
          cur.kill  <= 1'b0;
        end else if (ctl.shift_up) begin
          cur <= prev;
        end else if (ctl.shift_dn) begin
          cur <= nxt;
        end else if (ctl.merge) begin
          if (s < cur.start) cur.start <= s;
          if (e > cur.stop) cur.stop <= e;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/sise_list.sv
// One sorted list: a row of entry cells, its count and its search chains.
module sise_list import sise_pkg::*; #(
  parameter int MAX_INTERVALS = 16,
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  list_cmd_t        cmd,
  input  stamp_t           s,
  input  stamp_t           e,
  input  logic [3:0]       rd_index,
  output logic [CNT_W-1:0] count,
  output logic             rd_hit,
  output stamp_t           rd_start,
  output stamp_t           rd_stop,
  output list_stat_t       stat
);

  entry_t    cells [MAX_INTERVALS];
  cell_ctl_t ctl   [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] ge, le, valid, found, merge_v, rd_sel;
  logic [MAX_INTERVALS:0]   fb, kb;
  logic apply_ins;

  assign fb[0] = 1'b0;
  assign kb[0] = 1'b0;
  assign stat.merged   = |merge_v;
  assign stat.full     = (count == CNT_W'(MAX_INTERVALS));
  assign stat.any_kill = kb[MAX_INTERVALS];
  assign apply_ins = (cmd.op == LIST_APPLY) && cmd.sel && !stat.merged && !stat.full;

  for (genvar p = 0; p < MAX_INTERVALS; p++) begin : g_cell
    entry_t prev_e, nxt_e;

    assign valid[p]   = (CNT_W'(p) < count);
    // The first live entry that does not end before the new start.
    assign fb[p+1]    = fb[p] | (ge[p] & valid[p]);
    assign found[p]   = ge[p] & valid[p] & ~fb[p];
    assign merge_v[p] = found[p] & le[p];
    assign kb[p+1]    = kb[p] | cells[p].kill;
    assign rd_sel[p]  = valid[p] && (32'(rd_index) == p);

    if (p == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = cells[p-1];
    end
    if (p == MAX_INTERVALS - 1) begin : g_last
      assign nxt_e = '0;
    end else begin : g_inner
      assign nxt_e = cells[p+1];
    end

    always_comb begin
      ctl[p].valid = valid[p];
      case (cmd.op)
        LIST_EVAL:    ctl[p].op = CELL_EVAL;
        LIST_MARK:    ctl[p].op = CELL_MARK;
        LIST_APPLY:   ctl[p].op = cmd.sel ? CELL_MOVE : CELL_HOLD;
        LIST_SQUEEZE: ctl[p].op = CELL_MOVE;
        default:      ctl[p].op = CELL_HOLD;
      endcase
      ctl[p].take_new = apply_ins &&
                        (found[p] || (!fb[MAX_INTERVALS] && CNT_W'(p) == count));
      ctl[p].shift_up = apply_ins && fb[p] && (CNT_W'(p) <= count);
      ctl[p].shift_dn = (cmd.op == LIST_SQUEEZE) && kb[p+1];
      ctl[p].merge    = (cmd.op == LIST_APPLY) && cmd.sel && merge_v[p];
    end

    sise_cell u_cell (
      .clk  (clk),
      .ctl  (ctl[p]),
      .s    (s),
      .e    (e),
      .prev (prev_e),
      .nxt  (nxt_e),
      .cur  (cells[p]),
      .ge   (ge[p]),
      .le   (le[p])
    );
  end

  always_comb begin
    rd_hit   = |rd_sel;
    rd_start = '0;
    rd_stop  = '0;
    for (int p = 0; p < MAX_INTERVALS; p++) begin
      if (rd_sel[p]) begin
        rd_start = cells[p].start;
        rd_stop  = cells[p].stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == LIST_FLUSH) begin
      count <= '0;
    end else if (apply_ins) begin
      count <= count + 1'b1;
    end else if ((cmd.op == LIST_SQUEEZE) && kb[MAX_INTERVALS]) begin
      count <= count - 1'b1;
    end
  end

endmodule

// File: hdl/sorted_interval_set_engine.sv
// Top level of the sorted interval set engine.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+--------------------------------------------
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//   in      | in_valid / in_ready     | operation, busy_kind, span_start, span_end,
//           |                         | entry_index
//   out     | out_valid / out_ready   | outcome, entry_valid, entry_start, entry_end,
//           |                         | list_count
//
// A read, a flush or an ignored add goes from S_CLIP straight to S_RESP, which registers
// the result; an add that reaches the lists passes S_EVAL and S_APPLY first.
// A clear passes S_MARK and then stays in S_SQUEEZE until no list holds an entry to remove;
// the cells of a list close one gap per cycle.
// One request is worked on at a time; the next is taken the cycle after the result
// is in the output register, while that result waits for out_ready.
// Reset empties every list and restores the range registers.
module sorted_interval_set_engine import sise_pkg::*; #(
  parameter int MAX_INTERVALS = 16,
  parameter int NUM_LISTS     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [2:0]           busy_kind,
  input  logic [31:0]          span_start,
  input  logic [31:0]          span_end,
  input  logic [3:0]           entry_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           outcome,
  output logic                 entry_valid,
  output logic [31:0]          entry_start,
  output logic [31:0]          entry_end,
  output logic [4:0]           list_count
);

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int LST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLIP    = 3'd1;
  localparam logic [2:0] S_EVAL    = 3'd2;
  localparam logic [2:0] S_APPLY   = 3'd3;
  localparam logic [2:0] S_MARK    = 3'd4;
  localparam logic [2:0] S_SQUEEZE = 3'd5;
  localparam logic [2:0] S_RESP    = 3'd6;

  logic [2:0] state;
  logic [1:0] op_q;
  logic [2:0] kind_q;
  logic [3:0] idx_q;
  stamp_t     s_q, e_q, s_clip, e_clip;
  logic [1:0] outcome_q;
  stamp_t     range_start, range_end;

  logic             has_list;
  logic [LST_W-1:0] lst;
  logic [2:0]       kind_m1;
  list_cmd_t        cmd [NUM_LISTS];
  list_stat_t       stat [NUM_LISTS];
  logic [CNT_W-1:0] counts [NUM_LISTS];
  logic             hits [NUM_LISTS];
  stamp_t           rd_starts [NUM_LISTS];
  stamp_t           rd_stops [NUM_LISTS];
  logic             any_kill;
  logic [CNT_W+4:0] cnt_ext;
  logic [2:0]       list_op;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign kind_m1   = kind_q - 3'd1;
  assign lst       = kind_m1[LST_W-1:0];
  assign has_list  = (kind_q != 3'd0) && (32'(kind_q) <= NUM_LISTS);
  assign s_clip    = (s_q < range_start) ? range_start : s_q;
  assign e_clip    = (e_q > range_end) ? range_end : e_q;
  assign cnt_ext   = {5'd0, counts[lst]};

  always_comb begin
    case (state)
      S_CLIP:    list_op = (op_q == OP_FLUSH) ? LIST_FLUSH : LIST_HOLD;
      S_EVAL:    list_op = LIST_EVAL;
      S_APPLY:   list_op = LIST_APPLY;
      S_MARK:    list_op = LIST_MARK;
      S_SQUEEZE: list_op = LIST_SQUEEZE;
      default:   list_op = LIST_HOLD;
    endcase
  end

  always_comb begin
    any_kill = 1'b0;
    for (int g = 0; g < NUM_LISTS; g++) begin
      any_kill = any_kill | stat[g].any_kill;
    end
  end

  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_list
    assign cmd[g].op  = list_op;
    assign cmd[g].sel = has_list && (lst == LST_W'(g));

    sise_list #(.MAX_INTERVALS(MAX_INTERVALS)) u_list (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd[g]),
      .s        (s_q),
      .e        (e_q),
      .rd_index (idx_q),
      .count    (counts[g]),
      .rd_hit   (hits[g]),
      .rd_start (rd_starts[g]),
      .rd_stop  (rd_stops[g]),
      .stat     (stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_end   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RANGE_START: range_start <= cfg_data;
        REG_RANGE_END:   range_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q      <= operation;
            kind_q    <= busy_kind;
            idx_q     <= entry_index;
            s_q       <= span_start;
            e_q       <= span_end;
            outcome_q <= OUT_DONE;
            state     <= S_CLIP;
          end
        end
        S_CLIP: begin
          case (op_q)
            OP_ADD: begin
              s_q <= s_clip;
              e_q <= e_clip;
              if (!has_list || (e_clip <= s_clip)) begin
                outcome_q <= OUT_IGNORED;
                state     <= S_RESP;
              end else begin
                state <= S_EVAL;
              end
            end
            OP_CLEAR: state <= S_MARK;
            OP_READ: begin
              if (!has_list) outcome_q <= OUT_IGNORED;
              state <= S_RESP;
            end
            default: state <= S_RESP;
          endcase
        end
        S_EVAL:  state <= S_APPLY;
        S_APPLY: begin
          if (!stat[lst].merged && stat[lst].full) outcome_q <= OUT_FULL;
          state <= S_RESP;
        end
        S_MARK:    state <= S_SQUEEZE;
        S_SQUEEZE: if (!any_kill) state <= S_RESP;
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            outcome     <= outcome_q;
            entry_valid <= (op_q == OP_READ) && has_list && hits[lst];
            if ((op_q == OP_READ) && has_list && hits[lst]) begin
              entry_start <= rd_starts[lst];
              entry_end   <= rd_stops[lst];
            end else begin
              entry_start <= '0;
              entry_end   <= '0;
            end
            list_count  <= has_list ? cnt_ext[4:0] : 5'd0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/sise_checker.sv
// Port checks for the sorted interval set engine, bound to the top level.
module sise_checker import sise_pkg::*; #(
  parameter int MAX_INTERVALS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  outcome,
  input logic        entry_valid,
  input logic [31:0] entry_start,
  input logic [31:0] entry_end,
  input logic [4:0]  list_count
);

  // Only one request is in flight, so acceptance closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(list_count))
    else $error("stalled result changed");

  a_zero_times: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_valid |-> entry_start == 32'd0 && entry_end == 32'd0)
    else $error("times not zero without a valid entry");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_FULL |-> list_count == 5'(MAX_INTERVALS) && !entry_valid)
    else $error("full outcome with a list that is not full");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> outcome == OUT_DONE && list_count != 5'd0)
    else $error("valid entry with a bad outcome or an empty list");

endmodule

bind sorted_interval_set_engine sise_checker #(.MAX_INTERVALS(MAX_INTERVALS)) u_sise_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .outcome     (outcome),
  .entry_valid (entry_valid),
  .entry_start (entry_start),
  .entry_end   (entry_end),
  .list_count  (list_count)
);

// File: verif/sorted_interval_set_engine_tb.sv
// Self-checking testbench for the sorted interval set engine.
module sorted_interval_set_engine_tb;
  import sise_pkg::*;

  localparam int MAXN   = 16;
  localparam int NLISTS = 4;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  kind;
    logic [31:0] s;
    logic [31:0] e;
    logic [3:0]  idx;
  } request_t;

  typedef struct packed {
    logic [1:0]  res;
    logic        ev;
    logic [31:0] es;
    logic [31:0] ee;
    logic [4:0]  cnt;
  } answer_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] operation;
  logic [2:0] busy_kind;
  logic [31:0] span_start, span_end;
  logic [3:0] entry_index;
  logic out_valid, out_ready;
  logic [1:0] outcome;
  logic entry_valid;
  logic [31:0] entry_start, entry_end;
  logic [4:0] list_count;

  sorted_interval_set_engine i_dut (.*);

  // Predictor state.
  logic [31:0] iv_start [NLISTS][MAXN];
  logic [31:0] iv_end   [NLISTS][MAXN];
  int unsigned iv_count [NLISTS];
  logic [31:0] win_lo, win_hi;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit in_taken = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [1:0] insert_interval(int l, logic [31:0] s0, logic [31:0] e0);
    logic [31:0] s, e;
    int i, k, n;
    s = s0;
    e = e0;
    n = iv_count[l];
    if (s < win_lo) s = win_lo;
    if (e > win_hi) e = win_hi;
    if (e <= s) return OUT_IGNORED;
    for (i = 0; i < n; i++) if (iv_end[l][i] >= s) break;
    if (i < n && iv_start[l][i] <= e) begin
      if (s < iv_start[l][i]) iv_start[l][i] = s;
      if (e > iv_end[l][i]) iv_end[l][i] = e;
      return OUT_DONE;
    end
    if (n >= MAXN) return OUT_FULL;
    for (k = n; k > i; k--) begin
      iv_start[l][k] = iv_start[l][k-1];
      iv_end[l][k] = iv_end[l][k-1];
    end
    iv_start[l][i] = s;
    iv_end[l][i] = e;
    iv_count[l] = n + 1;
    return OUT_DONE;
  endfunction

  function automatic void clear_span(logic [31:0] s, logic [31:0] e);
    int i, k;
    for (int l = 0; l < NLISTS; l++) begin
      i = 0;
      while (i < iv_count[l]) begin
        if (iv_end[l][i] < s || iv_start[l][i] > e) begin
          i++;
          continue;
        end
        if (iv_start[l][i] > s) iv_start[l][i] = e;
        if (iv_end[l][i] < e) iv_end[l][i] = s;
        if (iv_start[l][i] >= iv_end[l][i]) begin
          for (k = i; k + 1 < iv_count[l]; k++) begin
            iv_start[l][k] = iv_start[l][k+1];
            iv_end[l][k] = iv_end[l][k+1];
          end
          iv_count[l]--;
        end else begin
          i++;
        end
      end
    end
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    bit has_list;
    int l;
    a = '0;
    has_list = (r.kind >= 1 && r.kind <= NLISTS);
    l = has_list ? r.kind - 1 : 0;
    case (r.op)
      OP_ADD: a.res = has_list ? insert_interval(l, r.s, r.e) : OUT_IGNORED;
      OP_CLEAR: clear_span(r.s, r.e);
      OP_READ: begin
        if (!has_list) a.res = OUT_IGNORED;
        else if (r.idx < iv_count[l]) begin
          a.ev = 1'b1;
          a.es = iv_start[l][r.idx];
          a.ee = iv_end[l][r.idx];
        end
      end
      default: for (int j = 0; j < NLISTS; j++) iv_count[j] = 0;
    endcase
    a.cnt = has_list ? iv_count[l][4:0] : '0;
    return a;
  endfunction

  // Remembers whether the request on offer was taken at the last rising edge.
  always @(posedge clk) in_taken <= in_valid && in_ready;

  // Request driver.
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request_t r;
        r = pending_requests.pop_front();
        in_valid <= 1'b1;
        operation <= r.op;
        busy_kind <= r.kind;
        span_start <= r.s;
        span_end <= r.e;
        entry_index <= r.idx;
        in_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                  ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink back-pressure.
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 9) < 7);
  end

  // Predict on acceptance, check results.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(predict_answer({operation, busy_kind, span_start,
                                                   span_end, entry_index}));
      end
      if (out_valid && out_ready) begin
        answer_t a;
        answer_t x;
        a = {outcome, entry_valid, entry_start, entry_end, list_count};
        if (expected_answers.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, a);
          errors++;
        end else begin
          x = expected_answers.pop_front();
          if (a.res !== x.res)
            $display("%0t: outcome exp %0d got %0d", $time, x.res, a.res);
          if (a.ev !== x.ev)
            $display("%0t: entry_valid exp %0d got %0d", $time, x.ev, a.ev);
          if (a.es !== x.es)
            $display("%0t: entry_start exp %h got %h", $time, x.es, a.es);
          if (a.ee !== x.ee)
            $display("%0t: entry_end exp %h got %h", $time, x.ee, a.ee);
          if (a.cnt !== x.cnt)
            $display("%0t: list_count exp %0d got %0d", $time, x.cnt, a.cnt);
          if (a !== x) errors++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sorted_interval_set_engine_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RANGE_START) win_lo = val;
    else win_hi = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic request_t rand_request(logic [31:0] base, int spread);
    request_t r;
    int p;
    p = $urandom_range(0, 99);
    r.op = (p < 55) ? OP_ADD : (p < 70) ? OP_CLEAR : (p < 98) ? OP_READ : OP_FLUSH;
    r.kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    r.s = base + $urandom_range(0, spread);
    r.e = ($urandom_range(0, 15) == 0) ? r.s - $urandom_range(0, 5) :
          r.s + $urandom_range(1, spread / 4 + 1);
    r.idx = 4'($urandom());
    if ($urandom_range(0, 19) == 0) begin
      r.s = $urandom();
      r.e = $urandom();
    end
    return r;
  endfunction

  task automatic push_req(logic [1:0] op, logic [2:0] k, logic [31:0] s, logic [31:0] e,
                          logic [3:0] idx);
    pending_requests.push_back({op, k, s, e, idx});
  endtask

  initial begin
    request_t r;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = '0;
    busy_kind = '0;
    span_start = '0;
    span_end = '0;
    entry_index = '0;
    out_ready = 1'b0;
    win_lo = 32'd0;
    win_hi = 32'hFFFF_FFFF;
    for (int l = 0; l < NLISTS; l++) iv_count[l] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: free kind, no-list kinds, extremes, merge, full list, clear split.
    push_req(OP_ADD, 3'd0, 32'd10, 32'd20, 4'd0);
    push_req(OP_ADD, 3'd7, 32'd10, 32'd20, 4'd0);
    push_req(OP_READ, 3'd0, 32'd0, 32'd0, 4'd0);
    push_req(OP_ADD, 3'd1, 32'd0, 32'hFFFF_FFFF, 4'd0);
    push_req(OP_ADD, 3'd2, 32'd50, 32'd50, 4'd0);
    push_req(OP_ADD, 3'd2, 32'd100, 32'd200, 4'd0);
    push_req(OP_ADD, 3'd2, 32'd300, 32'd400, 4'd0);
    push_req(OP_ADD, 3'd2, 32'd150, 32'd350, 4'd0);
    push_req(OP_READ, 3'd2, 32'd0, 32'd0, 4'd0);
    push_req(OP_READ, 3'd2, 32'd0, 32'd0, 4'd1);
    push_req(OP_READ, 3'd2, 32'd0, 32'd0, 4'd15);
    push_req(OP_CLEAR, 3'd5, 32'd120, 32'd130, 4'd0);
    push_req(OP_CLEAR, 3'd1, 32'd400, 32'd90, 4'd0);
    push_req(OP_READ, 3'd1, 32'd0, 32'd0, 4'd0);
    for (int j = 0; j < 17; j++)
      push_req(OP_ADD, 3'd4, 32'd1000 + 10 * j, 32'd1005 + 10 * j, 4'd0);
    push_req(OP_ADD, 3'd4, 32'd1001, 32'd1003, 4'd0);
    push_req(OP_READ, 3'd4, 32'd0, 32'd0, 4'd15);
    push_req(OP_FLUSH, 3'd3, 32'd0, 32'd0, 4'd0);
    push_req(OP_READ, 3'd4, 32'd0, 32'd0, 4'd0);
    drain();

    // Random phases under several range settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      logic [31:0] base;
      case (ph)
        0: begin write_reg(REG_RANGE_START, 32'd0); write_reg(REG_RANGE_END, 32'hFFFF_FFFF); end
        1: begin write_reg(REG_RANGE_START, 32'd500); write_reg(REG_RANGE_END, 32'd3000); end
        2: begin write_reg(REG_RANGE_START, 32'd4000); write_reg(REG_RANGE_END, 32'd100); end
        3: begin write_reg(REG_RANGE_START, 32'hFFFF_FF00); write_reg(REG_RANGE_END, 32'hFFFF_FFFF); end
        default: begin
          write_reg(REG_RANGE_START, $urandom_range(0, 1000));
          write_reg(REG_RANGE_END, $urandom_range(2000, 5000));
        end
      endcase
      base = (ph == 3) ? 32'hFFFF_FE00 : 32'd0;
      for (int j = 0; j < 200; j++) begin
        r = rand_request(base, 4000);
        if (ph == 3 && $urandom_range(0, 1)) r.s = 32'hFFFF_FFFF - $urandom_range(0, 3);
        pending_requests.push_back(r);
      end
      if (ph == 5) begin
        // Back-pressure burst: stall the sink while requests keep coming.
        while (pending_requests.size() > 150) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("sorted_interval_set_engine_tb: done, clean");
    else $display("sorted_interval_set_engine_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/sise_pkg.sv
hdl/sise_cell.sv
hdl/sise_list.sv
hdl/sorted_interval_set_engine.sv
hdl/sise_checker.sv
verif/sorted_interval_set_engine_tb.sv
